// ===== sv/yuvh_pkg.sv =====
package yuvh_pkg;

  localparam int unsigned COLOR_W = 8;
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned ADJ_W   = COLOR_W + 1;
  localparam int unsigned PROD_W  = ADJ_W + GAIN_W;
  localparam int unsigned ACC_W   = PROD_W + 2;
  localparam int unsigned DIVD_W  = 11;
  localparam int unsigned NUM_W   = DIVD_W + COLOR_W;
  localparam int unsigned DEN_W   = COLOR_W + 3;
  localparam int unsigned QUO_W   = 9;
  localparam int unsigned REM_W   = NUM_W + 1;

  localparam int unsigned FRAC_BITS_DEF = 13;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = GAIN_W;

  localparam logic [CFG_IDX_W-1:0] CFG_LUMA_OFFSET   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHROMA_OFFSET = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LUMA_GAIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_U_BLUE_GAIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_U_GREEN_GAIN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_V_GREEN_GAIN  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_V_RED_GAIN    = 3'd6;

  typedef struct packed {
    logic        [COLOR_W-1:0] luma_offset;
    logic        [COLOR_W-1:0] chroma_offset;
    logic signed [GAIN_W-1:0]  luma_gain;
    logic signed [GAIN_W-1:0]  u_blue_gain;
    logic signed [GAIN_W-1:0]  u_green_gain;
    logic signed [GAIN_W-1:0]  v_green_gain;
    logic signed [GAIN_W-1:0]  v_red_gain;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    luma_offset:   8'd16,
    chroma_offset: 8'd128,
    luma_gain:     16'sd9535,
    u_blue_gain:   16'sd16531,
    u_green_gain:  -16'sd3203,
    v_green_gain:  -16'sd6660,
    v_red_gain:    16'sd13074
  };

endpackage

// ===== sv/yuvh_color.sv =====
module yuvh_color #(
  parameter int unsigned FracBits = yuvh_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  yuvh_pkg::cfg_t                cfg_i,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [yuvh_pkg::COLOR_W-1:0]  luma_i,
  input  logic [yuvh_pkg::COLOR_W-1:0]  chroma_blue_i,
  input  logic [yuvh_pkg::COLOR_W-1:0]  chroma_red_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [yuvh_pkg::COLOR_W-1:0]  red_o,
  output logic [yuvh_pkg::COLOR_W-1:0]  green_o,
  output logic [yuvh_pkg::COLOR_W-1:0]  blue_o
);
  import yuvh_pkg::*;

  localparam logic signed [ACC_W-1:0] Round = ACC_W'(1) <<< (FracBits - 1);
  localparam logic signed [ACC_W-1:0] ColorMax = ACC_W'((1 << COLOR_W) - 1);

  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;

  logic signed [ADJ_W-1:0] ya_q, ua_q, va_q;
  logic signed [ADJ_W-1:0] ya_d, ua_d, va_d;
  logic signed [PROD_W-1:0] yw_q, vr_q, ug_q, vg_q, ub_q;
  logic signed [ACC_W-1:0] acc_r, acc_g, acc_b;
  logic [COLOR_W-1:0] red_q, green_q, blue_q;
  logic [COLOR_W-1:0] red_d, green_d, blue_d;

  function automatic logic [COLOR_W-1:0] clamp_color(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] q;
    q = acc >>> FracBits;
    if (q < 0) begin
      return '0;
    end else if (q > ColorMax) begin
      return '1;
    end
    return q[COLOR_W-1:0];
  endfunction

  assign rdy3    = !v3_q || ready_i;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;
  assign valid_o = v3_q;

  assign ya_d = $signed({1'b0, luma_i}) - $signed({1'b0, cfg_i.luma_offset});
  assign ua_d = $signed({1'b0, chroma_blue_i}) - $signed({1'b0, cfg_i.chroma_offset});
  assign va_d = $signed({1'b0, chroma_red_i}) - $signed({1'b0, cfg_i.chroma_offset});

  assign acc_r = ACC_W'(yw_q) + ACC_W'(vr_q) + Round;
  assign acc_g = ACC_W'(yw_q) + ACC_W'(ug_q) + ACC_W'(vg_q) + Round;
  assign acc_b = ACC_W'(yw_q) + ACC_W'(ub_q) + Round;

  assign red_d   = clamp_color(acc_r);
  assign green_d = clamp_color(acc_g);
  assign blue_d  = clamp_color(acc_b);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      ya_q <= ya_d;
      ua_q <= ua_d;
      va_q <= va_d;
    end
    if (rdy2) begin
      yw_q <= PROD_W'(ya_q) * PROD_W'(cfg_i.luma_gain);
      vr_q <= PROD_W'(va_q) * PROD_W'(cfg_i.v_red_gain);
      ug_q <= PROD_W'(ua_q) * PROD_W'(cfg_i.u_green_gain);
      vg_q <= PROD_W'(va_q) * PROD_W'(cfg_i.v_green_gain);
      ub_q <= PROD_W'(ua_q) * PROD_W'(cfg_i.u_blue_gain);
    end
    if (rdy3) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

endmodule

// ===== sv/yuvh_range.sv =====
module yuvh_range (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [yuvh_pkg::COLOR_W-1:0]  red_i,
  input  logic [yuvh_pkg::COLOR_W-1:0]  green_i,
  input  logic [yuvh_pkg::COLOR_W-1:0]  blue_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [yuvh_pkg::REM_W-1:0]    num_o,
  output logic [yuvh_pkg::DEN_W-1:0]    den_o
);
  import yuvh_pkg::*;

  localparam int unsigned SW = DIVD_W + 1;

  logic v4_q, v5_q;
  logic rdy4, rdy5;

  logic [COLOR_W-1:0] mx, mn, range_d, range_q;
  logic signed [SW-1:0] r_s, g_s, b_s, rng_s, divd_s;
  logic [DIVD_W-1:0] divd_q;
  logic zero_q;
  logic [REM_W-1:0] num_q, num_d;
  logic [DEN_W-1:0] den_q, den_d;

  assign rdy5    = !v5_q || ready_i;
  assign rdy4    = !v4_q || rdy5;
  assign ready_o = rdy4;
  assign valid_o = v5_q;

  always_comb begin
    mx = red_i;
    mn = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx) mx = blue_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
    range_d = mx - mn;
    r_s   = $signed(SW'(red_i));
    g_s   = $signed(SW'(green_i));
    b_s   = $signed(SW'(blue_i));
    rng_s = $signed(SW'(range_d));
    if (red_i == mx) begin
      divd_s = g_s - b_s + (rng_s <<< 2) + (rng_s <<< 1);
    end else if (green_i == mx) begin
      divd_s = b_s - r_s + (rng_s <<< 1);
    end else begin
      divd_s = r_s - g_s + (rng_s <<< 2);
    end
  end

  always_comb begin
    if (zero_q) begin
      num_d = '0;
      den_d = DEN_W'(1);
    end else begin
      num_d = (REM_W'(divd_q) << COLOR_W) - REM_W'(divd_q);
      den_d = (DEN_W'(range_q) << 2) + (DEN_W'(range_q) << 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy4) v4_q <= valid_i;
      if (rdy5) v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      divd_q  <= divd_s[DIVD_W-1:0];
      range_q <= range_d;
      zero_q  <= (range_d == '0);
    end
    if (rdy5) begin
      num_q <= num_d;
      den_q <= den_d;
    end
  end

  assign num_o = num_q;
  assign den_o = den_q;

endmodule

// ===== sv/yuvh_div_cell.sv =====
module yuvh_div_cell #(
  parameter int unsigned Shift = 0
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic [yuvh_pkg::REM_W-1:0]  rem_i,
  input  logic [yuvh_pkg::DEN_W-1:0]  den_i,
  input  logic [yuvh_pkg::QUO_W-1:0]  quo_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic [yuvh_pkg::REM_W-1:0]  rem_o,
  output logic [yuvh_pkg::DEN_W-1:0]  den_o,
  output logic [yuvh_pkg::QUO_W-1:0]  quo_o
);
  import yuvh_pkg::*;

  logic valid_q, rdy;
  logic [REM_W-1:0] trial;
  logic [REM_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q;
  logic [QUO_W-1:0] quo_q, quo_d;

  assign rdy     = !valid_q || ready_i;
  assign ready_o = rdy;
  assign valid_o = valid_q;

  assign trial = rem_i - (REM_W'(den_i) << Shift);

  always_comb begin
    rem_d = rem_i;
    quo_d = quo_i;
    if (!trial[REM_W-1]) begin
      rem_d        = trial;
      quo_d[Shift] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (rdy) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy) begin
      rem_q <= rem_d;
      den_q <= den_i;
      quo_q <= quo_d;
    end
  end

  assign rem_o = rem_q;
  assign den_o = den_q;
  assign quo_o = quo_q;

endmodule

// ===== sv/yuv_pixel_to_hue.sv =====
// Converts one Y/U/V pixel per item into an 8-bit hue (full circle = 255, low 8 bits
// kept). The pipeline takes one item every clock while the output side does not
// stall: registered stages form red, green and blue (offset, weighted products,
// round and clamp), further registers find the range and the dividend, and a
// chain of nine divider cells produces one quotient bit each. Stalls collapse bubbles
// stage by stage, so new items enter while a finished one waits at the output. Write
// the configuration registers only while no item is in flight; writes to unused
// indexes are ignored.
module yuv_pixel_to_hue #(
  parameter int unsigned FRACTION_BITS = yuvh_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_wr_en_i,
  input  logic [yuvh_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [yuvh_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [yuvh_pkg::COLOR_W-1:0]    luma_i,
  input  logic [yuvh_pkg::COLOR_W-1:0]    chroma_blue_i,
  input  logic [yuvh_pkg::COLOR_W-1:0]    chroma_red_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [yuvh_pkg::COLOR_W-1:0]    hue_value_o
);
  import yuvh_pkg::*;

  cfg_t cfg_q;

  logic color_ready, color_valid;
  logic [COLOR_W-1:0] red, green, blue;
  logic range_ready;

  logic             cell_valid [QUO_W+1];
  logic             cell_ready [QUO_W+1];
  logic [REM_W-1:0] cell_rem   [QUO_W+1];
  logic [DEN_W-1:0] cell_den   [QUO_W+1];
  logic [QUO_W-1:0] cell_quo   [QUO_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_wr_en_i) begin
      case (cfg_idx_i)
        CFG_LUMA_OFFSET:   cfg_q.luma_offset   <= cfg_data_i[COLOR_W-1:0];
        CFG_CHROMA_OFFSET: cfg_q.chroma_offset <= cfg_data_i[COLOR_W-1:0];
        CFG_LUMA_GAIN:     cfg_q.luma_gain     <= $signed(cfg_data_i);
        CFG_U_BLUE_GAIN:   cfg_q.u_blue_gain   <= $signed(cfg_data_i);
        CFG_U_GREEN_GAIN:  cfg_q.u_green_gain  <= $signed(cfg_data_i);
        CFG_V_GREEN_GAIN:  cfg_q.v_green_gain  <= $signed(cfg_data_i);
        CFG_V_RED_GAIN:    cfg_q.v_red_gain    <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  yuvh_color #(
    .FracBits(FRACTION_BITS)
  ) u_color (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .valid_i      (in_valid_i),
    .ready_o      (color_ready),
    .luma_i       (luma_i),
    .chroma_blue_i(chroma_blue_i),
    .chroma_red_i (chroma_red_i),
    .valid_o      (color_valid),
    .ready_i      (range_ready),
    .red_o        (red),
    .green_o      (green),
    .blue_o       (blue)
  );

  assign in_stall_o = !color_ready;

  yuvh_range u_range (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(color_valid),
    .ready_o(range_ready),
    .red_i  (red),
    .green_i(green),
    .blue_i (blue),
    .valid_o(cell_valid[0]),
    .ready_i(cell_ready[0]),
    .num_o  (cell_rem[0]),
    .den_o  (cell_den[0])
  );

  assign cell_quo[0] = '0;

  for (genvar i = 0; i < QUO_W; i++) begin : g_cell
    yuvh_div_cell #(
      .Shift(QUO_W - 1 - i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(cell_valid[i]),
      .ready_o(cell_ready[i]),
      .rem_i  (cell_rem[i]),
      .den_i  (cell_den[i]),
      .quo_i  (cell_quo[i]),
      .valid_o(cell_valid[i+1]),
      .ready_i(cell_ready[i+1]),
      .rem_o  (cell_rem[i+1]),
      .den_o  (cell_den[i+1]),
      .quo_o  (cell_quo[i+1])
    );
  end

  assign cell_ready[QUO_W] = !out_stall_i;
  assign out_valid_o       = cell_valid[QUO_W];
  assign hue_value_o       = cell_quo[QUO_W][COLOR_W-1:0];

endmodule

// ===== tb/tb_yuv_pixel_to_hue.sv =====
`timescale 1ns / 1ps

module tb_yuv_pixel_to_hue;
  import yuvh_pkg::*;

  localparam int unsigned FRAC_BITS       = FRAC_BITS_DEF;
  localparam int unsigned RESET_CYCLES    = 6;
  localparam int unsigned NUM_REGS        = 7;
  localparam int unsigned NUM_PHASES      = 10;
  localparam int unsigned ITEMS_PER_PHASE = 155;
  localparam int unsigned PHASE_DEFAULT   = 0;
  localparam int unsigned PHASE_UNIT      = 1;
  localparam int unsigned PHASE_EXT_A     = 2;
  localparam int unsigned PHASE_EXT_B     = 3;
  localparam int unsigned HOLD_PHASE      = 5;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned TAIL_CYCLES     = 40;
  localparam int unsigned WATCHDOG_LIMIT  = 4000;
  localparam int unsigned MAX_REPORTS     = 10;
  localparam int          COLOR_MAX       = 255;
  localparam int          HUE_CIRCLE      = 255;

  localparam logic [CFG_IDX_W-1:0]  CFG_IDX_NONE = 3'd7;
  localparam logic [CFG_DATA_W-1:0] UNIT_GAIN    = CFG_DATA_W'(1 << FRAC_BITS);
  localparam logic [CFG_DATA_W-1:0] GAIN_MIN     = 16'h8000;
  localparam logic [CFG_DATA_W-1:0] GAIN_MAX     = 16'h7FFF;

  typedef enum logic {ROW_PIXEL, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e               kind;
    logic [CFG_IDX_W-1:0]    idx;
    logic [CFG_DATA_W-1:0]   data;
    logic [COLOR_W-1:0]      y;
    logic [COLOR_W-1:0]      u;
    logic [COLOR_W-1:0]      v;
    logic                    typed;
    logic [COLOR_W-1:0]      hue;
  } step_t;

  localparam int unsigned NUM_STEPS = 32;
  localparam step_t STEPS [0:NUM_STEPS-1] = '{
    '{ROW_PIXEL, CFG_LUMA_OFFSET,   16'd0,    8'd16,  8'd128, 8'd128, 1'b1, 8'd0},
    '{ROW_PIXEL, CFG_LUMA_OFFSET,   16'd0,    8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
    '{ROW_PIXEL, CFG_LUMA_OFFSET,   16'd0,    8'd255, 8'd128, 8'd128, 1'b1, 8'd0},
    '{ROW_PIXEL, CFG_LUMA_OFFSET,   16'd0,    8'd0,   8'd128, 8'd128, 1'b1, 8'd0},
    '{ROW_PIXEL, CFG_LUMA_OFFSET,   16'd0,    8'd255, 8'd255, 8'd255, 1'b0, 8'd0},
    '{ROW_PIXEL, CFG_LUMA_OFFSET,   16'd0,    8'd0,   8'd255, 8'd0,   1'b0, 8'd0},
    '{ROW_PIXEL, CFG_LUMA_OFFSET,   16'd0,    8'd255, 8'd0,   8'd255, 1'b0, 8'd0},
    '{ROW_PIXEL, CFG_LUMA_OFFSET,   16'd0,    8'd128, 8'd0,   8'd0,   1'b0, 8'd0},
    '{ROW_PIXEL, CFG_LUMA_OFFSET,   16'd0,    8'd128, 8'd255, 8'd255, 1'b0, 8'd0},
    '{ROW_PIXEL, CFG_LUMA_OFFSET,   16'd0,    8'd81,  8'd90,  8'd240, 1'b0, 8'd0},
    '{ROW_PIXEL, CFG_LUMA_OFFSET,   16'd0,    8'd145, 8'd54,  8'd34,  1'b0, 8'd0},
    '{ROW_PIXEL, CFG_LUMA_OFFSET,   16'd0,    8'd41,  8'd240, 8'd110, 1'b0, 8'd0},
    '{ROW_REG,   CFG_IDX_NONE,      16'hFFFF, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
    '{ROW_PIXEL, CFG_LUMA_OFFSET,   16'd0,    8'd81,  8'd90,  8'd240, 1'b0, 8'd0},
    '{ROW_REG,   CFG_LUMA_OFFSET,   16'd0,    8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
    '{ROW_REG,   CFG_CHROMA_OFFSET, 16'hAB80, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
    '{ROW_REG,   CFG_LUMA_GAIN,     UNIT_GAIN, 8'd0,  8'd0,   8'd0,   1'b0, 8'd0},
    '{ROW_REG,   CFG_U_BLUE_GAIN,   UNIT_GAIN, 8'd0,  8'd0,   8'd0,   1'b0, 8'd0},
    '{ROW_REG,   CFG_U_GREEN_GAIN,  16'd0,    8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
    '{ROW_REG,   CFG_V_GREEN_GAIN,  16'd0,    8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
    '{ROW_REG,   CFG_V_RED_GAIN,    UNIT_GAIN, 8'd0,  8'd0,   8'd0,   1'b0, 8'd0},
    '{ROW_PIXEL, CFG_LUMA_OFFSET,   16'd0,    8'd100, 8'd50,  8'd128, 1'b1, 8'd41},
    '{ROW_PIXEL, CFG_LUMA_OFFSET,   16'd0,    8'd100, 8'd128, 8'd50,  1'b1, 8'd127},
    '{ROW_PIXEL, CFG_LUMA_OFFSET,   16'd0,    8'd100, 8'd128, 8'd128, 1'b1, 8'd0},
    '{ROW_PIXEL, CFG_LUMA_OFFSET,   16'd0,    8'd100, 8'd0,   8'd255, 1'b0, 8'd0},
    '{ROW_PIXEL, CFG_LUMA_OFFSET,   16'd0,    8'd0,   8'd255, 8'd255, 1'b0, 8'd0},
    '{ROW_PIXEL, CFG_LUMA_OFFSET,   16'd0,    8'd0,   8'd0,   8'd0,   1'b1, 8'd0},
    '{ROW_PIXEL, CFG_LUMA_OFFSET,   16'd0,    8'd200, 8'd255, 8'd0,   1'b0, 8'd0},
    '{ROW_REG,   CFG_LUMA_GAIN,     GAIN_MIN, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
    '{ROW_PIXEL, CFG_LUMA_OFFSET,   16'd0,    8'd255, 8'd200, 8'd60,  1'b0, 8'd0},
    '{ROW_REG,   CFG_V_RED_GAIN,    GAIN_MAX, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
    '{ROW_PIXEL, CFG_LUMA_OFFSET,   16'd0,    8'd0,   8'd0,   8'd255, 1'b0, 8'd0}
  };

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_wr_en_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = CFG_LUMA_OFFSET;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  in_valid_i    = 1'b0;
  logic                  in_stall_o;
  logic [COLOR_W-1:0]    luma_i        = '0;
  logic [COLOR_W-1:0]    chroma_blue_i = '0;
  logic [COLOR_W-1:0]    chroma_red_i  = '0;
  logic                  out_valid_o;
  logic                  out_stall_i   = 1'b0;
  logic [COLOR_W-1:0]    hue_value_o;

  cfg_t                hue_cfg = CFG_RESET;
  logic [COLOR_W-1:0]  expected_hues [$];
  int unsigned         hue_errors = 0;
  int unsigned         idle_cycles = 0;
  bit                  hold_req = 1'b0;
  bit                  no_gaps = 1'b0;

  yuv_pixel_to_hue #(
    .FRACTION_BITS(FRAC_BITS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .luma_i        (luma_i),
    .chroma_blue_i (chroma_blue_i),
    .chroma_red_i  (chroma_red_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .hue_value_o   (hue_value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int clamp_level(input longint acc);
    longint q;
    q = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (q < 0) return 0;
    if (q > COLOR_MAX) return COLOR_MAX;
    return int'(q);
  endfunction

  function automatic logic [COLOR_W-1:0] predict_hue(input logic [COLOR_W-1:0] y, u, v);
    longint ya, ua, va, yw;
    int r, g, b, top, bottom, span, dividend, q;
    ya = longint'(y) - longint'(hue_cfg.luma_offset);
    ua = longint'(u) - longint'(hue_cfg.chroma_offset);
    va = longint'(v) - longint'(hue_cfg.chroma_offset);
    yw = ya * longint'($signed(hue_cfg.luma_gain));
    r = clamp_level(yw + va * longint'($signed(hue_cfg.v_red_gain)));
    g = clamp_level(yw + ua * longint'($signed(hue_cfg.u_green_gain))
                       + va * longint'($signed(hue_cfg.v_green_gain)));
    b = clamp_level(yw + ua * longint'($signed(hue_cfg.u_blue_gain)));
    top = r;
    bottom = r;
    if (g > top) top = g;
    if (b > top) top = b;
    if (g < bottom) bottom = g;
    if (b < bottom) bottom = b;
    span = top - bottom;
    if (span == 0) return '0;
    if (r == top) dividend = g - b + 6 * span;
    else if (g == top) dividend = b - r + 2 * span;
    else dividend = r - g + 4 * span;
    q = (HUE_CIRCLE * dividend) / (6 * span);
    return q[COLOR_W-1:0];
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_LUMA_OFFSET:   hue_cfg.luma_offset   = data[COLOR_W-1:0];
      CFG_CHROMA_OFFSET: hue_cfg.chroma_offset = data[COLOR_W-1:0];
      CFG_LUMA_GAIN:     hue_cfg.luma_gain     = data;
      CFG_U_BLUE_GAIN:   hue_cfg.u_blue_gain   = data;
      CFG_U_GREEN_GAIN:  hue_cfg.u_green_gain  = data;
      CFG_V_GREEN_GAIN:  hue_cfg.v_green_gain  = data;
      CFG_V_RED_GAIN:    hue_cfg.v_red_gain    = data;
      default: ;
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] phase_reg_value(input int unsigned phase,
                                                            input logic [CFG_IDX_W-1:0] idx);
    logic [CFG_DATA_W-1:0] dflt, unit;
    int unsigned roll, span;
    bit is_offset;
    is_offset = (idx == CFG_LUMA_OFFSET) || (idx == CFG_CHROMA_OFFSET);
    case (idx)
      CFG_LUMA_OFFSET: begin
        dflt = CFG_DATA_W'(CFG_RESET.luma_offset);
        unit = '0;
      end
      CFG_CHROMA_OFFSET: begin
        dflt = CFG_DATA_W'(CFG_RESET.chroma_offset);
        unit = CFG_DATA_W'(CFG_RESET.chroma_offset);
      end
      CFG_LUMA_GAIN: begin
        dflt = CFG_RESET.luma_gain;
        unit = UNIT_GAIN;
      end
      CFG_U_BLUE_GAIN: begin
        dflt = CFG_RESET.u_blue_gain;
        unit = UNIT_GAIN;
      end
      CFG_U_GREEN_GAIN: begin
        dflt = CFG_RESET.u_green_gain;
        unit = '0;
      end
      CFG_V_GREEN_GAIN: begin
        dflt = CFG_RESET.v_green_gain;
        unit = '0;
      end
      default: begin
        dflt = CFG_RESET.v_red_gain;
        unit = UNIT_GAIN;
      end
    endcase
    case (phase)
      PHASE_DEFAULT: return dflt;
      PHASE_UNIT:    return unit;
      PHASE_EXT_A: begin
        if (is_offset) return (idx == CFG_LUMA_OFFSET) ? 16'h0000 : 16'h00FF;
        return idx[0] ? GAIN_MIN : GAIN_MAX;
      end
      PHASE_EXT_B: begin
        if (is_offset) return (idx == CFG_LUMA_OFFSET) ? 16'h00FF : 16'h0000;
        return idx[0] ? GAIN_MAX : GAIN_MIN;
      end
      default: ;
    endcase
    span = is_offset ? 20 : 1000;
    roll = $urandom_range(0, 99);
    if (roll < 50) return dflt + CFG_DATA_W'($urandom_range(0, 2 * span)) - CFG_DATA_W'(span);
    if (roll < 65) return CFG_DATA_W'($urandom);
    if (roll < 75) return is_offset ? 16'h0000 : GAIN_MIN;
    if (roll < 85) return is_offset ? 16'h00FF : GAIN_MAX;
    return unit;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (no_gaps || hold_req) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  task automatic drain_hues();
    in_valid_i <= 1'b0;
    while (expected_hues.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    drain_hues();
    cfg_wr_en_i <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    apply_reg(idx, data);
    cfg_wr_en_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_pixel(input logic [COLOR_W-1:0] y, u, v,
                            input logic typed, input logic [COLOR_W-1:0] hue);
    int unsigned gap;
    in_valid_i    <= 1'b1;
    luma_i        <= y;
    chroma_blue_i <= u;
    chroma_red_i  <= v;
    do @(posedge clk_i); while (in_stall_o);
    expected_hues.push_back(typed ? hue : predict_hue(y, u, v));
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin : stimulus
    int unsigned roll;
    logic [COLOR_W-1:0] y, u, v;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (STEPS[i]) begin
      if (STEPS[i].kind == ROW_REG) begin
        write_reg(STEPS[i].idx, STEPS[i].data);
      end else begin
        send_pixel(STEPS[i].y, STEPS[i].u, STEPS[i].v, STEPS[i].typed, STEPS[i].hue);
      end
    end
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      for (int k = 0; k < NUM_REGS; k++) begin
        write_reg(CFG_IDX_W'(k), phase_reg_value(phase, CFG_IDX_W'(k)));
      end
      write_reg(CFG_IDX_NONE, CFG_DATA_W'($urandom));
      no_gaps = (phase == PHASE_UNIT);
      if (phase == HOLD_PHASE) hold_req = 1'b1;
      repeat (ITEMS_PER_PHASE) begin
        roll = $urandom_range(0, 9);
        y = COLOR_W'($urandom);
        u = COLOR_W'($urandom);
        v = COLOR_W'($urandom);
        if (roll == 6 || roll == 7) begin
          u = hue_cfg.chroma_offset + COLOR_W'($urandom_range(0, 6)) - 8'd3;
          v = hue_cfg.chroma_offset + COLOR_W'($urandom_range(0, 6)) - 8'd3;
        end else if (roll == 8) begin
          y = {COLOR_W{y[0]}};
          u = {COLOR_W{u[0]}};
          v = {COLOR_W{v[0]}};
        end else if (roll == 9) begin
          u = y;
          v = y;
        end
        send_pixel(y, u, v, 1'b0, '0);
      end
    end
    drain_hues();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (hue_errors == 0 && expected_hues.size() == 0) begin
      $display("yuv_pixel_to_hue regression: pass");
    end else begin
      $display("yuv_pixel_to_hue regression: fail");
    end
    $finish;
  end

  initial begin : output_pacing
    int unsigned run_len, stall_len, n;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 20);
      out_stall_i <= 1'b0;
      n = 0;
      do begin
        @(posedge clk_i);
        n++;
      end while (n < run_len && !hold_req);
      stall_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      out_stall_i <= 1'b1;
      n = 0;
      do begin
        @(posedge clk_i);
        n++;
      end while (n < stall_len && !hold_req);
    end
  end

  always @(posedge clk_i) begin : hue_check
    logic [COLOR_W-1:0] want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_hues.size() == 0) begin
        if (hue_errors < MAX_REPORTS) $display("hue %0d arrived with none pending", hue_value_o);
        hue_errors++;
      end else begin
        want = expected_hues.pop_front();
        if (hue_value_o !== want) begin
          if (hue_errors < MAX_REPORTS) begin
            $display("hue_value mismatch: expected %0d, got %0d", want, hue_value_o);
          end
          hue_errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_wr_en_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("yuv_pixel_to_hue regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// ===== sim.f =====
sv/yuvh_pkg.sv
sv/yuvh_color.sv
sv/yuvh_range.sv
sv/yuvh_div_cell.sv
sv/yuv_pixel_to_hue.sv
tb/tb_yuv_pixel_to_hue.sv
